// ===== sv/lsra_pkg.sv =====
// Shared types and constants for the linear scan register allocator.
package lsra_pkg;

  localparam int NumRegs  = 16;
  localparam int UsedRegs = (NumRegs < 16) ? NumRegs : 16;
  localparam int IdxW     = (UsedRegs > 1) ? $clog2(UsedRegs) : 1;
  localparam int CntW     = $clog2(UsedRegs + 1);
  localparam int PosW     = 16;
  localparam int VarW     = 16;
  localparam int MaskW    = 16;
  localparam int RegW     = 4;
  localparam int SlotW    = 16;
  localparam logic [SlotW-1:0] SlotMax = '1;

  typedef struct packed {
    logic            first;
    logic [VarW-1:0] var_id;
    logic [PosW-1:0] start_pos;
    logic [PosW-1:0] end_pos;
  } item_t;

  typedef struct packed {
    logic [PosW-1:0] end_pos;
    logic [VarW-1:0] var_id;
  } entry_t;

  typedef struct packed {
    logic [VarW-1:0] var_id;
    logic            got_reg;
    logic [IdxW-1:0] reg_idx;
    logic            spill_valid;
    logic [VarW-1:0] spilled_var;
  } decision_t;

endpackage

// ===== sv/lsra_entry_mem.sv =====
// Active table storage: end position and variable per register, registered read.
module lsra_entry_mem (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [lsra_pkg::IdxW-1:0]      waddr_i,
  input  lsra_pkg::entry_t               wdata_i,
  input  logic [lsra_pkg::IdxW-1:0]      raddr_i,
  output lsra_pkg::entry_t               rdata_o
);

  lsra_pkg::entry_t mem_q [lsra_pkg::UsedRegs];
  lsra_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lsra_scan.sv =====
// Sequencer: walks the active table, retires expired entries and picks a register.
module lsra_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  lsra_pkg::item_t               item_i,
  input  logic [lsra_pkg::MaskW-1:0]    avail_mask_i,
  output logic                          idle_o,
  output logic                          res_valid_o,
  output lsra_pkg::decision_t           res_o,
  input  logic                          res_ack_i
);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StDecide,
    StHold
  } state_e;

  state_e                         state_q, state_d;
  lsra_pkg::item_t                item_q, item_d;
  logic [lsra_pkg::UsedRegs-1:0]  valid_q, valid_d;
  logic [lsra_pkg::CntW-1:0]      issue_q, issue_d;
  logic                           chk_vld_q, chk_vld_d;
  logic [lsra_pkg::IdxW-1:0]      chk_idx_q, chk_idx_d;
  logic                           cand_found_q, cand_found_d;
  logic [lsra_pkg::IdxW-1:0]      cand_idx_q, cand_idx_d;
  lsra_pkg::entry_t               cand_q, cand_d;
  lsra_pkg::decision_t            res_q, res_d;

  lsra_pkg::entry_t               rdata;
  lsra_pkg::entry_t               wdata;
  logic                           mem_we;
  logic [lsra_pkg::UsedRegs-1:0]  open_regs;
  logic                           free_found;
  logic [lsra_pkg::IdxW-1:0]      free_idx;

  lsra_entry_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (res_q.reg_idx),
    .wdata_i (wdata),
    .raddr_i (issue_q[lsra_pkg::IdxW-1:0]),
    .rdata_o (rdata)
  );

  assign wdata.end_pos = item_q.end_pos;
  assign wdata.var_id  = item_q.var_id;
  assign mem_we        = (state_q == StHold) && res_ack_i && res_q.got_reg;

  assign open_regs = avail_mask_i[lsra_pkg::UsedRegs-1:0] & ~valid_q;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int r = lsra_pkg::UsedRegs - 1; r >= 0; r--) begin
      if (open_regs[r]) begin
        free_found = 1'b1;
        free_idx   = lsra_pkg::IdxW'(r);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    valid_d      = valid_q;
    issue_d      = issue_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    cand_found_d = cand_found_q;
    cand_idx_d   = cand_idx_q;
    cand_d       = cand_q;
    res_d        = res_q;

    if (chk_vld_q && valid_q[chk_idx_q]) begin
      if (rdata.end_pos < item_q.start_pos) begin
        valid_d[chk_idx_q] = 1'b0;
      end else if (!cand_found_q || (rdata.end_pos > cand_q.end_pos)) begin
        cand_found_d = 1'b1;
        cand_idx_d   = chk_idx_q;
        cand_d       = rdata;
      end
    end

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          item_d       = item_i;
          issue_d      = '0;
          cand_found_d = 1'b0;
          if (item_i.first) begin
            valid_d = '0;
          end
          state_d = StScan;
        end
      end
      StScan: begin
        chk_vld_d = 1'b1;
        chk_idx_d = issue_q[lsra_pkg::IdxW-1:0];
        issue_d   = issue_q + lsra_pkg::CntW'(1);
        if (issue_q == lsra_pkg::CntW'(lsra_pkg::UsedRegs - 1)) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StDecide;
      end
      StDecide: begin
        res_d.var_id = item_q.var_id;
        if (free_found) begin
          res_d.got_reg     = 1'b1;
          res_d.reg_idx     = free_idx;
          res_d.spill_valid = 1'b0;
          res_d.spilled_var = '0;
        end else if (cand_found_q && (cand_q.end_pos > item_q.end_pos)) begin
          res_d.got_reg     = 1'b1;
          res_d.reg_idx     = cand_idx_q;
          res_d.spill_valid = 1'b1;
          res_d.spilled_var = cand_q.var_id;
        end else begin
          res_d.got_reg     = 1'b0;
          res_d.reg_idx     = '0;
          res_d.spill_valid = 1'b1;
          res_d.spilled_var = item_q.var_id;
        end
        state_d = StHold;
      end
      StHold: begin
        if (res_ack_i) begin
          if (res_q.got_reg) begin
            valid_d[res_q.reg_idx] = 1'b1;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      valid_q   <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    issue_q      <= issue_d;
    chk_idx_q    <= chk_idx_d;
    cand_found_q <= cand_found_d;
    cand_idx_q   <= cand_idx_d;
    cand_q       <= cand_d;
    res_q        <= res_d;
  end

  assign idle_o      = (state_q == StIdle);
  assign res_valid_o = (state_q == StHold);
  assign res_o       = res_q;

endmodule

// ===== sv/linear_scan_register_allocator_core.sv =====
// Top level: stream ports, mask register, spill counter and result register.
//
// Each live interval is handled in a sequence of steps, since the
// active table sits in one memory with a single registered read port, and one
// comparator checks one entry per cycle for expiry and for the spill candidate.
// The steps are the accept, a read of every table entry, the return of the last
// read, the decision and the hand-off to the output register; the hand-off waits
// while the output register is full and m_axis_tready is low. A new
// interval is taken while the previous result still waits in the output
// register. The availability mask resets to all ones; write it only while no
// interval is in flight.
module linear_scan_register_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,     // avail_mask
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // var_id, start_pos, end_pos
  input  logic        s_axis_tuser,   // first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // var_id_out, got_reg, reg_index, spill_valid,
                                      // spilled_var, spill_slot, slot_saturated, pad
);

  logic [lsra_pkg::MaskW-1:0] mask_q;
  logic [lsra_pkg::SlotW-1:0] count_q;
  logic                       out_valid_q;
  logic [55:0]                out_q;

  lsra_pkg::item_t            item;
  lsra_pkg::decision_t        res;
  logic                       idle;
  logic                       res_valid;
  logic                       res_ack;
  logic                       in_xact;
  logic                       sat;

  assign item.first     = s_axis_tuser;
  assign item.var_id    = s_axis_tdata[15:0];
  assign item.start_pos = s_axis_tdata[31:16];
  assign item.end_pos   = s_axis_tdata[47:32];

  assign s_axis_tready = idle;
  assign in_xact       = s_axis_tvalid && idle;
  assign res_ack       = res_valid && (!out_valid_q || m_axis_tready);
  assign sat           = (count_q == lsra_pkg::SlotMax);
  assign cfg_ready_o   = 1'b1;

  lsra_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_xact),
    .item_i       (item),
    .avail_mask_i (mask_q),
    .idle_o       (idle),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ack_i    (res_ack)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '1;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mask_q <= cfg_data_i;
      end
      if (in_xact && item.first) begin
        count_q <= '0;
      end else if (res_ack && res.spill_valid && !sat) begin
        count_q <= count_q + lsra_pkg::SlotW'(1);
      end
      if (res_ack) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      out_q[15:0]  <= res.var_id;
      out_q[16]    <= res.got_reg;
      out_q[20:17] <= res.got_reg ? lsra_pkg::RegW'(res.reg_idx) : '0;
      out_q[21]    <= res.spill_valid;
      out_q[37:22] <= res.spill_valid ? res.spilled_var : '0;
      out_q[53:38] <= res.spill_valid ? count_q : '0;
      out_q[54]    <= res.spill_valid && sat;
      out_q[55]    <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the linear scan register allocator core.
module tb_top;

  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 40;
  localparam int MaxReports  = 40;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  // Result fields, last field in the top bits to match m_axis_tdata[54:0].
  typedef struct packed {
    logic                       slot_saturated;
    logic [lsra_pkg::SlotW-1:0] spill_slot;
    logic [lsra_pkg::VarW-1:0]  spilled_var;
    logic                       spill_valid;
    logic [lsra_pkg::RegW-1:0]  reg_index;
    logic                       got_reg;
    logic [lsra_pkg::VarW-1:0]  var_id;
  } alloc_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;  // var_id, start_pos, end_pos
  logic        s_axis_tuser  = 1'b0;  // first
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;  // var_id_out, got_reg, reg_index, spill_valid,
                              // spilled_var, spill_slot, slot_saturated, pad

  linear_scan_register_allocator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Allocator state mirrored by the testbench.
  logic [lsra_pkg::MaskW-1:0] avail_regs = 16'hFFFF;
  logic                       live_valid [lsra_pkg::NumRegs] = '{default: 1'b0};
  logic [lsra_pkg::PosW-1:0]  live_end   [lsra_pkg::NumRegs] = '{default: '0};
  logic [lsra_pkg::VarW-1:0]  live_var   [lsra_pkg::NumRegs] = '{default: '0};
  logic [lsra_pkg::SlotW-1:0] next_slot = '0;

  alloc_result_t expected_allocs[$];

  int err_cnt        = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int functions_seen = 0;
  int spills_seen    = 0;
  int evictions_seen = 0;
  int saturated_seen = 0;
  int mask_writes    = 0;
  int input_stalls   = 0;

  bit       tx_gaps_on   = 1'b1;
  int       burst_left   = 0;
  rx_mode_e rx_mode      = RX_RANDOM;
  int       rx_stall_pct = 30;
  int       rx_period    = 2;
  int       rx_duty      = 1;
  int       rx_tick      = 0;
  int       hold_left    = 0;

  function automatic alloc_result_t allocate_interval(input lsra_pkg::item_t iv);
    alloc_result_t res;
    int            r;
    int            pick;
    int            victim;
    res = '0;
    res.var_id = iv.var_id;
    pick = -1;
    victim = -1;
    if (iv.first) begin
      for (r = 0; r < lsra_pkg::NumRegs; r++) live_valid[r] = 1'b0;
      next_slot = '0;
      functions_seen++;
    end
    for (r = 0; r < lsra_pkg::NumRegs; r++) begin
      if (live_valid[r] && live_end[r] < iv.start_pos) live_valid[r] = 1'b0;
    end
    for (r = 0; r < lsra_pkg::UsedRegs && pick < 0; r++) begin
      if (avail_regs[r] && !live_valid[r]) pick = r;
    end
    if (pick < 0) begin
      for (r = 0; r < lsra_pkg::NumRegs; r++) begin
        if (live_valid[r] && (victim < 0 || live_end[r] > live_end[victim])) victim = r;
      end
      res.spill_valid    = 1'b1;
      res.spill_slot     = next_slot;
      res.slot_saturated = (next_slot == lsra_pkg::SlotMax);
      if (next_slot != lsra_pkg::SlotMax) next_slot++;
      else saturated_seen++;
      spills_seen++;
      if (victim >= 0 && live_end[victim] > iv.end_pos) begin
        pick = victim;
        res.spilled_var = live_var[victim];
        evictions_seen++;
      end else begin
        res.spilled_var = iv.var_id;
      end
    end
    if (pick >= 0) begin
      live_valid[pick] = 1'b1;
      live_end[pick]   = iv.end_pos;
      live_var[pick]   = iv.var_id;
      res.got_reg      = 1'b1;
      res.reg_index    = pick[lsra_pkg::RegW-1:0];
    end
    return res;
  endfunction

  function automatic lsra_pkg::item_t make_interval(input logic first,
                                                    input logic [15:0] var_id,
                                                    input logic [15:0] start_pos,
                                                    input logic [15:0] end_pos);
    lsra_pkg::item_t iv;
    iv.first     = first;
    iv.var_id    = var_id;
    iv.start_pos = start_pos;
    iv.end_pos   = end_pos;
    return iv;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] want_v,
                                 input logic [15:0] got_v);
    err_cnt++;
    if (err_cnt <= MaxReports) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    alloc_result_t got;
    alloc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[54:0];
      results_seen++;
      if (expected_allocs.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReports) begin
          $display("%0t: unexpected transaction: expected none, got %h", $time, got);
        end
      end else begin
        want = expected_allocs.pop_front();
        if (got.var_id !== want.var_id)
          report_mismatch("var_id_out", want.var_id, got.var_id);
        if (got.got_reg !== want.got_reg)
          report_mismatch("got_reg", want.got_reg, got.got_reg);
        if (got.reg_index !== want.reg_index)
          report_mismatch("reg_index", want.reg_index, got.reg_index);
        if (got.spill_valid !== want.spill_valid)
          report_mismatch("spill_valid", want.spill_valid, got.spill_valid);
        if (got.spilled_var !== want.spilled_var)
          report_mismatch("spilled_var", want.spilled_var, got.spilled_var);
        if (got.spill_slot !== want.spill_slot)
          report_mismatch("spill_slot", want.spill_slot, got.spill_slot);
        if (got.slot_saturated !== want.slot_saturated)
          report_mismatch("slot_saturated", want.slot_saturated, got.slot_saturated);
      end
    end
  end

  always @(negedge clk_i) begin
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_RANDOM: m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        default:   m_axis_tready <= ((rx_tick % rx_period) < rx_duty);
      endcase
    end
  end

  task automatic send_interval(input lsra_pkg::item_t iv);
    int            gap;
    alloc_result_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = tx_gaps_on ? $urandom_range(1, 40) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {iv.end_pos, iv.start_pos, iv.var_id};
    s_axis_tuser  <= iv.first;
    do begin
      @(posedge clk_i);
      if (!s_axis_tready) input_stalls++;
    end while (!s_axis_tready);
    want = allocate_interval(iv);
    expected_allocs = {expected_allocs, want};
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (expected_allocs.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_avail_mask(input logic [15:0] mask);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mask;
    do @(posedge clk_i); while (!cfg_ready_o);
    avail_regs = mask;
    mask_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_free_register_order();
    write_avail_mask(16'hFFFF);
    send_interval(make_interval(1'b1, 16'h0000, 16'h0000, 16'hFFFF));
    send_interval(make_interval(1'b0, 16'hFFFF, 16'h0000, 16'd5));
    send_interval(make_interval(1'b0, 16'h1234, 16'd6, 16'd10));
    wait_drained();
  endtask

  task automatic test_eviction_and_ties();
    write_avail_mask(16'h0003);
    send_interval(make_interval(1'b1, 16'd1, 16'd0, 16'd100));
    send_interval(make_interval(1'b0, 16'd2, 16'd0, 16'd200));
    send_interval(make_interval(1'b0, 16'd3, 16'd1, 16'd150));
    send_interval(make_interval(1'b0, 16'd4, 16'd2, 16'd150));
    send_interval(make_interval(1'b1, 16'd10, 16'd0, 16'd300));
    send_interval(make_interval(1'b0, 16'd11, 16'd0, 16'd300));
    send_interval(make_interval(1'b0, 16'd12, 16'd1, 16'd100));
    wait_drained();
  endtask

  task automatic test_mask_change_in_function();
    write_avail_mask(16'hFFFF);
    send_interval(make_interval(1'b1, 16'd20, 16'd0, 16'd500));
    send_interval(make_interval(1'b0, 16'd21, 16'd0, 16'd500));
    write_avail_mask(16'h0004);
    send_interval(make_interval(1'b0, 16'd22, 16'd1, 16'd600));
    send_interval(make_interval(1'b0, 16'd23, 16'd2, 16'd50));
    send_interval(make_interval(1'b0, 16'd24, 16'd700, 16'd800));
    // start goes backward: nothing retires
    send_interval(make_interval(1'b0, 16'd25, 16'd3, 16'd900));
    wait_drained();
  endtask

  task automatic test_restart_and_positions();
    write_avail_mask(16'h8000);
    send_interval(make_interval(1'b1, 16'hFFFF, 16'hFFFF, 16'h0000));
    send_interval(make_interval(1'b0, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_interval(make_interval(1'b0, 16'hAAAA, 16'hFFFF, 16'hFFFF));
    send_interval(make_interval(1'b1, 16'h5555, 16'h0000, 16'h0000));
    send_interval(make_interval(1'b0, 16'h0001, 16'h0000, 16'h0000));
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    int k;
    write_avail_mask(16'hFFFF);
    tx_gaps_on = 1'b0;
    rx_mode    = RX_ALWAYS;
    hold_left  = 400;
    for (k = 0; k < 12; k++) begin
      send_interval(make_interval(k == 0, 16'($urandom), 16'(k * 3), 16'(k * 3 + 20)));
    end
    wait_drained();
  endtask

  task automatic run_random_phase(input logic [15:0] mask, input int n_items,
                                  input bit gaps, input rx_mode_e mode);
    lsra_pkg::item_t iv;
    int              fn_len;
    int              sent;
    int              k;
    int              roll;
    int              pos;
    int              span;
    write_avail_mask(mask);
    tx_gaps_on   = gaps;
    rx_mode      = mode;
    rx_stall_pct = $urandom_range(10, 70);
    rx_period    = $urandom_range(2, 48);
    rx_duty      = $urandom_range(1, rx_period - 1);
    sent = 0;
    while (sent < n_items) begin
      fn_len = $urandom_range(1, 48);
      pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2000);
      for (k = 0; k < fn_len && sent < n_items; k++) begin
        roll = $urandom_range(0, 99);
        iv.first  = (k == 0) && (roll >= 5);
        iv.var_id = 16'($urandom);
        if (roll >= 92) begin
          iv.start_pos = 16'($urandom);
          iv.end_pos   = 16'($urandom);
        end else begin
          pos = pos + $urandom_range(0, 3);
          if (pos > 65535) pos = 65535;
          span = (roll < 15) ? $urandom_range(0, 65535) : $urandom_range(0, 30);
          iv.start_pos = 16'(pos);
          iv.end_pos   = (pos + span > 65535) ? 16'hFFFF : 16'(pos + span);
        end
        send_interval(iv);
        sent++;
      end
    end
    wait_drained();
  endtask

  task automatic test_random_functions();
    run_random_phase(16'hFFFF, 300, 1'b0, RX_ALWAYS);
    run_random_phase(16'hFFFF, 300, 1'b1, RX_RANDOM);
    run_random_phase(16'h000F, 300, 1'b1, RX_PATTERN);
    run_random_phase(16'h0001, 250, 1'b1, RX_RANDOM);
    run_random_phase(16'h8000, 200, 1'b0, RX_PATTERN);
    run_random_phase(16'($urandom_range(1, 65535)), 300, 1'b1, RX_RANDOM);
    run_random_phase(16'($urandom_range(1, 65535)), 300, 1'b1, RX_PATTERN);
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycles, expected_allocs.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_free_register_order();
    test_eviction_and_ties();
    test_mask_change_in_function();
    test_restart_and_positions();
    test_output_backpressure();
    test_random_functions();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d intervals in %0d functions under %0d mask writes, %0d results checked",
             items_sent, functions_seen, mask_writes, results_seen);
    $display("saw %0d spills, %0d evictions, %0d saturated slots, %0d input stall cycles",
             spills_seen, evictions_seen, saturated_seen, input_stalls);
    if (err_cnt == 0 && expected_allocs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
